>>> sv/qpes_pkg.sv
`timescale 1ns / 1ps

package qpes_pkg;

    // Width of one node id field on the stream ports
    localparam int ID_FIELD_BITS = 32;
    // Default compare width of a node id
    localparam int NODE_ID_BITS_DEF = 32;
    // Corners per quad and ids per word
    localparam int CORNERS = 4;
    localparam int IDS_PER_WORD = 2 * CORNERS;
    localparam int DATA_BITS = IDS_PER_WORD * ID_FIELD_BITS;
    localparam int MASK_BITS = CORNERS * CORNERS;

    // Match patterns for a single shared edge run in opposite directions:
    // entry 4a+b holds bit 4a+b and bit 4(a+1)+(b-1), indices mod 4.
    localparam logic [MASK_BITS-1:0] EDGE_PAT [MASK_BITS] = '{
        16'h0081, 16'h0012, 16'h0024, 16'h0048,
        16'h0810, 16'h0120, 16'h0240, 16'h0480,
        16'h8100, 16'h1200, 16'h2400, 16'h4800,
        16'h1008, 16'h2001, 16'h4002, 16'h8004
    };

    typedef logic [1:0] corner_t;

    // Decoded swap: hit flag and the matching corner of each quad
    typedef struct packed {
        logic    hit;
        corner_t a;
        corner_t b;
    } swap_sel_t;

endpackage

>>> sv/qpes_decode.sv
`timescale 1ns / 1ps

module qpes_decode
    import qpes_pkg::*;
(
    input  logic [MASK_BITS-1:0] mask,
    output swap_sel_t            sel
);

    // Patterns are all distinct, so at most one entry can hit
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < MASK_BITS; i++)
        begin
            if (mask == EDGE_PAT[i])
            begin
                sel.hit = 1'b1;
                sel.a   = corner_t'(i / CORNERS);
                sel.b   = corner_t'(i % CORNERS);
            end
        end
    end

endmodule

>>> sv/quad_pair_edge_swap.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata                                        tuser
// s_*      in   first_n0..3, second_n0..3 (32 b each)        orient
// m_*      out  new_first_n0..3, new_second_n0..3 (32 b)     swapped
//
// Three register stages: compare mask, pattern decode, ring select and
// output register. One word enters every cycle unless a stall fills them all.
// Reset clears only the stage valid bits. A stall on m_tready holds every
// full stage; empty stages still fill, so s_tready drops only when all
// three stages hold a word.

module quad_pair_edge_swap
    import qpes_pkg::*;
#(
    parameter int NODE_ID_BITS = NODE_ID_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,   // first_n0..n3, second_n0..n3
    input  logic                 s_tuser,   // orient
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,   // new_first_n0..n3, new_second_n0..n3
    output logic                 m_tuser    // swapped
);

    localparam int IdW = (NODE_ID_BITS < ID_FIELD_BITS) ? NODE_ID_BITS : ID_FIELD_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // Stage 1: ids and match mask
    logic [IdW-1:0]       id1_reg [IDS_PER_WORD];
    logic                 orient1_reg;
    logic [MASK_BITS-1:0] mask1_reg;
    logic [MASK_BITS-1:0] mask1_next;

    // Stage 2: ids and decoded swap
    logic [IdW-1:0] id2_reg [IDS_PER_WORD];
    logic           orient2_reg;
    swap_sel_t      sel2_reg;
    swap_sel_t      sel2_next;

    // Stage 3: output word
    logic [ID_FIELD_BITS-1:0] out3_reg  [IDS_PER_WORD];
    logic [ID_FIELD_BITS-1:0] out3_next [IDS_PER_WORD];
    logic                     swapped3_reg;

    logic [IdW-1:0] nd [6];

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign m_tvalid = v3_reg;
    assign m_tuser  = swapped3_reg;

    always_comb
    begin
        for (int i = 0; i < IDS_PER_WORD; i++)
        begin
            m_tdata[i*ID_FIELD_BITS +: ID_FIELD_BITS] = out3_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Bit 4a+b set when first[a] matches second[b]
    always_comb
    begin
        for (int a = 0; a < CORNERS; a++)
        begin
            for (int b = 0; b < CORNERS; b++)
            begin
                mask1_next[a*CORNERS + b] =
                    s_tdata[a*ID_FIELD_BITS +: IdW] ==
                    s_tdata[(CORNERS + b)*ID_FIELD_BITS +: IdW];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            for (int i = 0; i < IDS_PER_WORD; i++)
            begin
                id1_reg[i] <= s_tdata[i*ID_FIELD_BITS +: IdW];
            end
            orient1_reg <= s_tuser;
            mask1_reg   <= mask1_next;
        end
    end

    qpes_decode u_decode
    (
        .mask (mask1_reg),
        .sel  (sel2_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            id2_reg     <= id1_reg;
            orient2_reg <= orient1_reg;
            sel2_reg    <= sel2_next;
        end
    end

    // Build the six-node ring, then pick the new pair by orientation
    always_comb
    begin
        nd[0] = id2_reg[{1'b0, sel2_reg.a}];
        nd[1] = id2_reg[{1'b1, corner_t'(sel2_reg.b + 2'd1)}];
        nd[2] = id2_reg[{1'b1, corner_t'(sel2_reg.b + 2'd2)}];
        nd[3] = id2_reg[{1'b0, corner_t'(sel2_reg.a + 2'd1)}];
        nd[4] = id2_reg[{1'b0, corner_t'(sel2_reg.a + 2'd2)}];
        nd[5] = id2_reg[{1'b0, corner_t'(sel2_reg.a + 2'd3)}];
        for (int i = 0; i < IDS_PER_WORD; i++)
        begin
            out3_next[i] = '0;
        end
        if (!sel2_reg.hit)
        begin
            for (int i = 0; i < IDS_PER_WORD; i++)
            begin
                out3_next[i][IdW-1:0] = id2_reg[i];
            end
        end
        else if (orient2_reg)
        begin
            out3_next[0][IdW-1:0] = nd[1];
            out3_next[1][IdW-1:0] = nd[2];
            out3_next[2][IdW-1:0] = nd[3];
            out3_next[3][IdW-1:0] = nd[4];
            out3_next[4][IdW-1:0] = nd[0];
            out3_next[5][IdW-1:0] = nd[1];
            out3_next[6][IdW-1:0] = nd[4];
            out3_next[7][IdW-1:0] = nd[5];
        end
        else
        begin
            out3_next[0][IdW-1:0] = nd[0];
            out3_next[1][IdW-1:0] = nd[1];
            out3_next[2][IdW-1:0] = nd[2];
            out3_next[3][IdW-1:0] = nd[5];
            out3_next[4][IdW-1:0] = nd[2];
            out3_next[5][IdW-1:0] = nd[3];
            out3_next[6][IdW-1:0] = nd[4];
            out3_next[7][IdW-1:0] = nd[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            out3_reg     <= out3_next;
            swapped3_reg <= sel2_reg.hit;
        end
    end

endmodule
